@@ hdl/psb_pkg.sv @@
package psb_pkg;

    typedef struct packed {
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_z;
        logic               final_item;
    } psb_in_t;

    typedef struct packed {
        logic [1:0]         axis;
        logic signed [19:0] origin;
        logic [19:0]        extent;
        logic               valid_res;
        logic               last_axis;
    } psb_out_t;

    localparam logic [2:0] REG_BOUNDED_DIMS = 3'd0;
    localparam logic [2:0] REG_COMPUTE_UNB  = 3'd1;
    localparam logic [2:0] REG_SPREAD       = 3'd2;
    localparam logic [2:0] REG_BOX_X        = 3'd3;
    localparam logic [2:0] REG_BOX_Y        = 3'd4;
    localparam logic [2:0] REG_BOX_Z        = 3'd5;

    localparam int CFG_W = 19;
    localparam int SUM_W = 40;
    localparam int SQ_W  = 60;

endpackage

@@ hdl/position_spread_bounds.sv @@
// Sequence: a non-final beat is taken at the accepting edge, then one multiply-accumulate runs
// per axis. After a final beat a bounded or disabled axis passes S_AXIS and S_OUT; a computed axis
// adds three serial divisions, a square root and the single steps S_MSQ, S_VAR, S_SPR and S_FIN.
// A result also waits until the previous result beat has left the output register.
// The block is not ready for a new input beat while it works on one.
// Reset: asynchronous active low; sums and count clear, config registers take their reset values.
module position_spread_bounds
    import psb_pkg::*;
#(
    parameter int MAX_ITEMS = 1048576,
    parameter int NUM_AXES  = 3
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic           in_valid,
    output logic           in_ready,
    input  psb_in_t        in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output psb_out_t       out_data
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_ACC    = 12'b000000000010,
        S_AXIS   = 12'b000000000100,
        S_DIVM   = 12'b000000001000,
        S_DIVQ   = 12'b000000010000,
        S_DIVR   = 12'b000000100000,
        S_MSQ    = 12'b000001000000,
        S_VAR    = 12'b000010000000,
        S_SQRT   = 12'b000100000000,
        S_SPR    = 12'b001000000000,
        S_FIN    = 12'b010000000000,
        S_OUT    = 12'b100000000000
    } state_t;

    state_t state_reg;
    logic [1:0]  bdims_reg;
    logic        cunb_reg;
    logic [15:0] sf_reg;
    logic [18:0] box_reg [3];

    logic signed [SUM_W-1:0] csum_reg [3];
    logic [SQ_W-1:0]         ssum_reg [3];
    logic [CNT_W-1:0]        cnt_reg;

    psb_in_t    item_reg;
    logic [1:0] ax_reg;
    logic       fin_reg;

    // shared divider: 64-bit dividend, 21-bit divisor, one bit a cycle
    logic [63:0] dvd_reg;
    logic [63:0] quo_reg;
    logic [21:0] rem_reg;
    logic [6:0]  step_reg;
    logic        neg_reg;
    logic signed [41:0] mean_reg;
    logic [59:0] q_reg;
    logic signed [81:0] var_reg;
    logic [81:0] sqv_reg;
    logic [81:0] root_reg;
    logic [81:0] bit_reg;
    logic [40:0] sd_reg;
    logic [57:0] sp_reg;
    psb_out_t    out_reg;
    logic        ov_reg;

    logic [CNT_W-1:0] n;
    assign n = (cnt_reg == '0) ? CNT_W'(1) : cnt_reg;

    logic [21:0] rem_sh;
    logic        rem_ge;
    logic [21:0] rem_nx;
    assign rem_sh = {rem_reg[20:0], dvd_reg[63]};
    assign rem_ge = rem_sh >= 22'(n);
    assign rem_nx = rem_ge ? rem_sh - 22'(n) : rem_sh;

    // The mean rounds half away from zero from the final remainder.
    logic [41:0] mean_up;
    assign mean_up = {quo_reg[40:0], rem_ge} + (({rem_nx, 1'b0} >= 23'(n)) ? 42'd1 : 42'd0);

    logic [29:0] mmag;
    logic [59:0] mean_sq;
    assign mmag    = 30'(mean_reg[41] ? -mean_reg : mean_reg);
    assign mean_sq = mmag * mmag;

    logic signed [19:0] pcur;
    always_comb
    begin
        unique case (ax_reg)
            2'd0:    pcur = item_reg.pos_x;
            2'd1:    pcur = item_reg.pos_y;
            default: pcur = item_reg.pos_z;
        endcase
    end

    logic signed [39:0] psq;
    assign psq = pcur * pcur;

    logic [81:0] rb;
    assign rb = root_reg + bit_reg;

    logic signed [SUM_W-1:0] sabs;
    assign sabs = csum_reg[ax_reg] < 0 ? -csum_reg[ax_reg] : csum_reg[ax_reg];

    logic signed [59:0] o_pre;
    assign o_pre = (60'(mean_reg) - signed'(60'(sp_reg)) + 60'sd512) >>> 10;

    logic [58:0] e_pre;
    assign e_pre = (59'(sp_reg) * 59'd2 + 59'd512) >> 10;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bdims_reg <= 2'd3;
            cunb_reg  <= 1'b1;
            sf_reg    <= 16'd7094;
            for (int i = 0; i < 3; i++)
            begin
                box_reg[i]  <= '0;
                csum_reg[i] <= '0;
                ssum_reg[i] <= '0;
            end
            cnt_reg   <= '0;
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            ax_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BOUNDED_DIMS: bdims_reg  <= cfg_data[1:0];
                    REG_COMPUTE_UNB:  cunb_reg   <= cfg_data[0];
                    REG_SPREAD:       sf_reg     <= cfg_data[15:0];
                    REG_BOX_X:        box_reg[0] <= cfg_data[18:0];
                    REG_BOX_Y:        box_reg[1] <= cfg_data[18:0];
                    REG_BOX_Z:        box_reg[2] <= cfg_data[18:0];
                    default: ;
                endcase
            end
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg  <= in_data;
                        fin_reg   <= in_data.final_item;
                        ax_reg    <= '0;
                        if (cnt_reg < CNT_W'(MAX_ITEMS))
                            state_reg <= S_ACC;
                        else if (in_data.final_item)
                            state_reg <= S_AXIS;
                    end
                end
                S_ACC:
                begin
                    csum_reg[ax_reg] <= csum_reg[ax_reg] + SUM_W'(pcur);
                    ssum_reg[ax_reg] <= ssum_reg[ax_reg] + SQ_W'(unsigned'(psq));
                    if (ax_reg == 2'd2)
                    begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        ax_reg    <= '0;
                        state_reg <= fin_reg ? S_AXIS : S_IDLE;
                    end
                    else
                        ax_reg <= ax_reg + 1'b1;
                end
                S_AXIS:
                begin
                    if (!ov_reg)
                    begin
                        out_reg.axis      <= ax_reg;
                        out_reg.last_axis <= (32'(ax_reg) == NUM_AXES - 1);
                        out_reg.origin    <= '0;
                        if (ax_reg < bdims_reg)
                        begin
                            out_reg.extent    <= 20'(box_reg[ax_reg]);
                            out_reg.valid_res <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else if (!cunb_reg)
                        begin
                            out_reg.extent    <= '0;
                            out_reg.valid_res <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            out_reg.valid_res <= 1'b1;
                            neg_reg   <= csum_reg[ax_reg] < 0;
                            dvd_reg   <= 64'(unsigned'(sabs)) << 10;
                            rem_reg   <= '0;
                            step_reg  <= '0;
                            state_reg <= S_DIVM;
                        end
                    end
                end
                S_DIVM, S_DIVQ, S_DIVR:
                begin
                    quo_reg <= {quo_reg[62:0], rem_ge};
                    if (step_reg == 7'd63)
                    begin
                        step_reg <= '0;
                        rem_reg  <= '0;
                        if (state_reg == S_DIVM)
                        begin
                            mean_reg  <= neg_reg ? -signed'(mean_up) : signed'(mean_up);
                            dvd_reg   <= 64'(ssum_reg[ax_reg]);
                            state_reg <= S_DIVQ;
                        end
                        else if (state_reg == S_DIVQ)
                        begin
                            q_reg     <= 60'({quo_reg[62:0], rem_ge});
                            dvd_reg   <= 64'(rem_nx) << 20;
                            state_reg <= S_DIVR;
                        end
                        else
                            state_reg <= S_MSQ;
                    end
                    else
                    begin
                        rem_reg  <= rem_nx;
                        dvd_reg  <= {dvd_reg[62:0], 1'b0};
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_MSQ:
                begin
                    var_reg   <= signed'(82'({q_reg, 20'd0}) + 82'(quo_reg) - 82'(mean_sq));
                    state_reg <= S_VAR;
                end
                S_VAR:
                begin
                    sqv_reg   <= var_reg[81] ? '0 : var_reg;
                    root_reg  <= '0;
                    bit_reg   <= 82'(1) << 80;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (bit_reg == '0)
                    begin
                        sd_reg    <= 41'(root_reg);
                        state_reg <= S_SPR;
                    end
                    else
                    begin
                        if (sqv_reg >= rb)
                        begin
                            sqv_reg  <= sqv_reg - rb;
                            root_reg <= (root_reg >> 1) + bit_reg;
                        end
                        else
                            root_reg <= root_reg >> 1;
                        bit_reg <= bit_reg >> 2;
                    end
                end
                S_SPR:
                begin
                    sp_reg    <= (58'(sf_reg) * 58'(sd_reg) + 58'd2048) >> 12;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (o_pre < -60'sd524288)
                        out_reg.origin <= -20'sd524288;
                    else if (o_pre > 60'sd524287)
                        out_reg.origin <= 20'sd524287;
                    else
                        out_reg.origin <= 20'(o_pre);
                    out_reg.extent <= (e_pre > 59'd1048575) ? 20'hFFFFF : 20'(e_pre);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    ov_reg <= 1'b1;
                    if (32'(ax_reg) == NUM_AXES - 1)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            csum_reg[i] <= '0;
                            ssum_reg[i] <= '0;
                        end
                        cnt_reg   <= '0;
                        ax_reg    <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 1'b1;
                        state_reg <= S_AXIS;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && cnt_reg < CNT_W'(MAX_ITEMS) |=> !in_ready);
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> out_data.axis <= 2'd2)
        else $error("axis out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.valid_res |-> out_data.extent == '0)
        else $error("invalid result with extent");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CNT_W'(MAX_ITEMS))
        else $error("count overflow");

endmodule
